### rtl/wave_1d_leapfrog_mur_step_core_defines.svh
// assertion macros for the wave line step core
// used by the top level, expects clk and rst_n in scope
`ifndef WAVE_1D_LEAPFROG_MUR_STEP_CORE_DEFINES_SVH
`define WAVE_1D_LEAPFROG_MUR_STEP_CORE_DEFINES_SVH

// property holds at every edge outside reset
`define WLM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define WLM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/wlm_pkg.sv
// shared types, widths and arithmetic helpers of the wave line step core
// no dependencies
package wlm_pkg;

  localparam int MAX_CELLS = 64;
  localparam int OUT_CELLS = 20;
  localparam int MIN_CELLS = 3;
  localparam int CELL_AW   = $clog2(MAX_CELLS);
  localparam int CELL_CW   = 7;
  localparam int AMP_W     = 32;
  localparam int COEF_W    = 24;
  localparam int IDX_W     = 5;
  localparam int FRAC_W    = 20;
  localparam int OPND_W    = AMP_W + 1;
  localparam int PROD_W    = COEF_W + OPND_W;
  localparam int RND_W     = PROD_W - FRAC_W;
  localparam int SUM_W     = RND_W + 2;
  localparam int CFG_AW    = 2;

  localparam logic signed [AMP_W-1:0]  AMP_MAX  = {1'b0, {(AMP_W-1){1'b1}}};
  localparam logic signed [AMP_W-1:0]  AMP_MIN  = {1'b1, {(AMP_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] CC_RESET = COEF_W'(2 << FRAC_W);
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1 << (FRAC_W - 1));

  typedef enum logic [CFG_AW-1:0] {
    REG_CENTRE    = 2'd0,
    REG_NEIGHBOUR = 2'd1,
    REG_ABSORBER  = 2'd2,
    REG_CELLS     = 2'd3
  } cfg_reg_t;

  typedef logic signed [AMP_W-1:0] amp_t;

  // round half up back to q.20
  function automatic logic signed [RND_W-1:0] rnd_q20(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + RND_HALF;
    return t[PROD_W-1:FRAC_W];
  endfunction

  function automatic amp_t sat_amp(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(AMP_MAX)) return AMP_MAX;
    if (v < SUM_W'(AMP_MIN)) return AMP_MIN;
    return v[AMP_W-1:0];
  endfunction

endpackage

### rtl/wlm_in_if.sv
// input channel: one drive amplitude word per timestep
// depends on wlm_pkg
interface wlm_in_if import wlm_pkg::*;;
  logic valid;
  logic ready;
  amp_t drive_amplitude;

  modport source (output valid, output drive_amplitude, input ready);
  modport sink   (input valid, input drive_amplitude, output ready);
endinterface

### rtl/wlm_out_if.sv
// result channel: one new cell amplitude word per handshake
// depends on wlm_pkg
interface wlm_out_if import wlm_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] cell_index;
  amp_t             cell_amplitude;
  logic             last_of_step;

  modport source (output valid, output cell_index, output cell_amplitude,
                  output last_of_step, input ready);
  modport sink   (input valid, input cell_index, input cell_amplitude,
                  input last_of_step, output ready);
endinterface

### rtl/wlm_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module wlm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/wave_1d_leapfrog_mur_step_core.sv
// Timestep core of a 1-D leapfrog wave line with a first-order Mur absorber at the far end.
// Each input word drives cell 0; the core then sweeps cells 1 to N-2 with the leapfrog
// update, closes cell N-1 with the Mur update and sends the new amplitudes of cells 1 to
// min(20, N-1), the last one flagged. All products go through one shared 24x33 multiplier,
// two passes per interior cell. A new input word is accepted only in idle, after the previous
// timestep, which the result side can hold up by stalling. Cell state lives in two 64-entry
// rams that swap roles per cell; per-entry valid bits make the state read as zero after reset,
// so no clearing pass is needed. Depends on wlm_pkg, wlm_in_if, wlm_out_if, wlm_ram and the
// assertion macro header.
`include "wave_1d_leapfrog_mur_step_core_defines.svh"

module wave_1d_leapfrog_mur_step_core import wlm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_AW-1:0]  cfg_index,
  input  logic [COEF_W-1:0]  cfg_data,
  wlm_in_if.sink             in_chan,
  wlm_out_if.source          out_chan
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_PRIME = 8'b0000_0010,
    ST_PWAIT = 8'b0000_0100,
    ST_MA    = 8'b0000_1000,
    ST_MB    = 8'b0001_0000,
    ST_FIN   = 8'b0010_0000,
    ST_MUR_M = 8'b0100_0000,
    ST_MUR_A = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [COEF_W-1:0] cc_r, cn_r, ca_r;
  logic [CELL_CW-1:0]       cells_r;

  logic [CELL_CW-1:0] n_r;
  logic [IDX_W-1:0]   cnt_r;
  amp_t               drive_r;
  logic [CELL_AW-1:0] i_r;
  logic [CELL_CW-1:0] rd_addr_r;
  logic               rd_pend_r;
  logic               pend_r;

  amp_t w_prev_r, w_cur_r, w_next_r, b_cur_r, b_next_r, bsub_r;
  logic signed [RND_W-1:0]  acc_r;
  logic signed [PROD_W-1:0] p_r;
  logic signed [OPND_W-1:0] d_r;

  logic [MAX_CELLS-1:0] sel_r, va_r, vb_r;
  logic rsel_r, rva_r, rvb_r;

  logic               out_valid_r;
  logic [IDX_W-1:0]   out_idx_r;
  amp_t               out_amp_r;
  logic               out_last_r;

  logic signed [COEF_W-1:0] mul_coef;
  logic signed [OPND_W-1:0] mul_val;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [RND_W-1:0]  rnd;
  logic signed [SUM_W-1:0]  int_sum, mur_sum;
  amp_t                     fresh_int, fresh_mur, cmp_val;
  logic [CELL_AW-1:0]       cmp_idx, waddr, raddr;
  logic                     complete, emit, stall, adv, we, we_a, we_b, re;
  amp_t                     wdata, rd_a, rd_b, now_rd, before_rd;
  logic [CELL_CW-1:0]       n_acc;
  logic [CELL_CW-1:0]       n_m1;
  logic                     in_acc;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r    <= CC_RESET;
      cn_r    <= '0;
      ca_r    <= '0;
      cells_r <= CELL_CW'(MAX_CELLS);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTRE:    cc_r    <= cfg_data;
        REG_NEIGHBOUR: cn_r    <= cfg_data;
        REG_ABSORBER:  ca_r    <= cfg_data;
        REG_CELLS:     cells_r <= cfg_data[CELL_CW-1:0];
        default: ;
      endcase
    end
  end

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign n_acc = (cells_r < CELL_CW'(MIN_CELLS)) ? CELL_CW'(MIN_CELLS) :
                 (cells_r > CELL_CW'(MAX_CELLS)) ? CELL_CW'(MAX_CELLS) : cells_r;
  assign n_m1  = n_acc - CELL_CW'(1);

  // shared multiplier operand select
  always_comb begin
    mul_coef = cc_r;
    mul_val  = OPND_W'(w_cur_r);
    unique case (state_r)
      ST_MB: begin
        mul_coef = cn_r;
        mul_val  = OPND_W'(w_prev_r) + OPND_W'(w_next_r);
      end
      ST_MUR_M: begin
        mul_coef = ca_r;
        mul_val  = d_r;
      end
      default: ;
    endcase
  end

  assign mul_p     = mul_coef * mul_val;
  assign rnd       = rnd_q20(p_r);
  assign int_sum   = SUM_W'(acc_r) + SUM_W'(rnd) - SUM_W'(bsub_r);
  assign mur_sum   = SUM_W'(w_cur_r) + SUM_W'(rnd);
  assign fresh_int = sat_amp(int_sum);
  assign fresh_mur = sat_amp(mur_sum);

  // cell completion and result push
  always_comb begin
    complete = 1'b0;
    cmp_idx  = i_r;
    cmp_val  = fresh_int;
    unique case (state_r)
      ST_MA: begin
        complete = pend_r;
        cmp_idx  = i_r - CELL_AW'(1);
      end
      ST_FIN: complete = 1'b1;
      ST_MUR_A: begin
        complete = 1'b1;
        cmp_idx  = CELL_AW'(n_r - CELL_CW'(1));
        cmp_val  = fresh_mur;
      end
      default: ;
    endcase
  end

  assign emit  = complete && (CELL_CW'(cmp_idx) <= CELL_CW'(cnt_r));
  assign stall = emit && out_valid_r && !out_chan.ready;
  assign adv   = !stall;

  // state rams: the bank not holding the current value of a cell takes its new value
  assign we    = adv && (complete || (state_r == ST_MUR_M));
  assign waddr = (state_r == ST_MUR_M) ? '0 : cmp_idx;
  assign wdata = (state_r == ST_MUR_M) ? drive_r : cmp_val;
  assign we_a  = we && sel_r[waddr];
  assign we_b  = we && !sel_r[waddr];

  assign re    = adv && ((state_r == ST_PRIME) ||
                 ((state_r == ST_MA) && (rd_addr_r <= n_r - CELL_CW'(1))));
  assign raddr = rd_addr_r[CELL_AW-1:0];

  wlm_ram #(.WIDTH(AMP_W), .DEPTH(MAX_CELLS)) u_bank_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_a)
  );

  wlm_ram #(.WIDTH(AMP_W), .DEPTH(MAX_CELLS)) u_bank_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_b)
  );

  always_comb begin
    if (rsel_r) begin
      now_rd    = rvb_r ? rd_b : '0;
      before_rd = rva_r ? rd_a : '0;
    end else begin
      now_rd    = rva_r ? rd_a : '0;
      before_rd = rvb_r ? rd_b : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r     <= '0;
      va_r      <= '0;
      vb_r      <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= re;
      if (we) begin
        sel_r[waddr] <= ~sel_r[waddr];
        if (we_a) begin
          va_r[waddr] <= 1'b1;
        end else begin
          vb_r[waddr] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rsel_r <= sel_r[raddr];
      rva_r  <= va_r[raddr];
      rvb_r  <= vb_r[raddr];
    end
    // sliding window over the current and previous values
    if (rd_pend_r) begin
      w_prev_r <= w_cur_r;
      w_cur_r  <= w_next_r;
      w_next_r <= now_rd;
      b_cur_r  <= b_next_r;
      b_next_r <= before_rd;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_PRIME;
      ST_PRIME: if (rd_addr_r == CELL_CW'(2)) state_nxt = ST_PWAIT;
      ST_PWAIT: state_nxt = ST_MA;
      ST_MA:    if (adv) state_nxt = ST_MB;
      ST_MB:    state_nxt = (i_r == CELL_AW'(n_r - CELL_CW'(2))) ? ST_FIN : ST_MA;
      ST_FIN:   if (adv) state_nxt = ST_MUR_M;
      ST_MUR_M: state_nxt = ST_MUR_A;
      ST_MUR_A: if (adv) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) begin
        pend_r <= 1'b0;
      end else if (state_r == ST_MB) begin
        pend_r <= 1'b1;
      end else if (adv && (state_r == ST_MA || state_r == ST_FIN)) begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      drive_r   <= in_chan.drive_amplitude;
      n_r       <= n_acc;
      cnt_r     <= (n_m1 > CELL_CW'(OUT_CELLS)) ? IDX_W'(OUT_CELLS) : n_m1[IDX_W-1:0];
      rd_addr_r <= '0;
      i_r       <= CELL_AW'(1);
    end
    if (re) begin
      rd_addr_r <= rd_addr_r + CELL_CW'(1);
    end
    if (adv) begin
      unique case (state_r)
        ST_MA:    p_r <= mul_p;
        ST_MB: begin
          p_r    <= mul_p;
          acc_r  <= rnd;
          bsub_r <= b_cur_r;
          if (i_r != CELL_AW'(n_r - CELL_CW'(2))) begin
            i_r <= i_r + CELL_AW'(1);
          end
        end
        ST_FIN:   d_r <= OPND_W'(fresh_int) - OPND_W'(w_next_r);
        ST_MUR_M: p_r <= mul_p;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit && adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && adv) begin
      out_idx_r  <= cmp_idx[IDX_W-1:0];
      out_amp_r  <= cmp_val;
      out_last_r <= (cmp_idx == CELL_AW'(cnt_r));
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.cell_index     = out_idx_r;
  assign out_chan.cell_amplitude = out_amp_r;
  assign out_chan.last_of_step   = out_last_r;

  `WLM_ASSERT_IMPL(a_shift_state, rd_pend_r, (state_r == ST_PRIME || state_r == ST_PWAIT || state_r == ST_MB), "window shift outside read states")
  `WLM_ASSERT_IMPL(a_stall_state, stall, (state_r == ST_MA || state_r == ST_FIN || state_r == ST_MUR_A), "stall outside completion states")
  `WLM_ASSERT_IMPL(a_emit_range, emit, (cmp_idx != '0), "result for cell zero")
  `WLM_ASSERT_IMPL(a_sweep_range, state_r == ST_MA, (i_r != '0 && CELL_CW'(i_r) <= n_r - CELL_CW'(2)), "interior index out of range")
  `WLM_ASSERT_NEXT(a_step_end, (state_r == ST_MUR_A && adv), (state_r == ST_IDLE && !pend_r), "step did not close")

endmodule
